// File: src/ucpd_pkg.sv
// ----------------------------------------------------------------------------
// ucpd_pkg
// Shared types and constants for the UTF-8 code point decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ucpd_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CodeW    = 21;
  localparam int unsigned PartialW = 15;
  localparam int unsigned LeftW    = 2;
  localparam int unsigned ContW    = 6;

  // continuation bytes still expected
  localparam logic [LeftW-1:0] LeftIdle  = 2'd0;
  localparam logic [LeftW-1:0] LeftOne   = 2'd1;
  localparam logic [LeftW-1:0] LeftTwo   = 2'd2;
  localparam logic [LeftW-1:0] LeftThree = 2'd3;

  // lead byte masks
  localparam logic [ByteW-1:0] Lead2Mask = 8'h1F;
  localparam logic [ByteW-1:0] Lead3Mask = 8'h0F;
  localparam logic [ByteW-1:0] Lead4Mask = 8'h07;
  localparam logic [ByteW-1:0] ContMask  = 8'h3F;

  // one result item from the decode stage
  typedef struct packed {
    logic             valid;
    logic [CodeW-1:0] code_point;
    logic             stop;
  } ucpd_res_t;

endpackage : ucpd_pkg

`default_nettype wire

// File: src/ucpd_in_stage.sv
// ----------------------------------------------------------------------------
// ucpd_in_stage
// Input register: holds one byte until the decode stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ucpd_in_stage (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic [ucpd_pkg::ByteW-1:0] in_byte,
  output logic                           in_stall,
  input  wire logic                      advance_i,
  output logic                           item_valid_o,
  output logic [ucpd_pkg::ByteW-1:0]     item_byte_o
);
  import ucpd_pkg::*;

  logic             valid_r;
  logic             valid_nxt;
  logic [ByteW-1:0] byte_r;
  logic             take;

  // a new transfer is taken when the register is empty or drains this cycle
  assign take     = !valid_r || advance_i;
  assign in_stall = !take;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk) begin
    if (take && in_valid) begin
      byte_r <= in_byte;
    end
  end

  assign item_valid_o = valid_r;
  assign item_byte_o  = byte_r;

endmodule : ucpd_in_stage

`default_nettype wire

// File: src/ucpd_decode.sv
// ----------------------------------------------------------------------------
// ucpd_decode
// Decode step: sequence state plus the per-byte mask, shift and count.
// ----------------------------------------------------------------------------
`default_nettype none

module ucpd_decode (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      step_i,
  input  wire logic [ucpd_pkg::ByteW-1:0] byte_i,
  output ucpd_pkg::ucpd_res_t            res_o
);
  import ucpd_pkg::*;

  logic [PartialW-1:0] partial_r;
  logic [PartialW-1:0] partial_nxt;
  logic [LeftW-1:0]    left_r;
  logic [LeftW-1:0]    left_nxt;
  logic [CodeW-1:0]    shifted;

  // gathered bits with the low six bits of this byte appended
  assign shifted = {partial_r, byte_i[ContW-1:0]};

  // next state and result for the byte on the input
  always_comb begin
    partial_nxt      = partial_r;
    left_nxt         = left_r;
    res_o.valid      = 1'b0;
    res_o.code_point = '0;
    res_o.stop       = 1'b0;
    if (left_r != LeftIdle) begin
      if (left_r == LeftOne) begin
        partial_nxt      = '0;
        left_nxt         = LeftIdle;
        res_o.valid      = 1'b1;
        res_o.code_point = shifted;
      end else begin
        partial_nxt = shifted[PartialW-1:0];
        left_nxt    = left_r - LeftOne;
      end
    end else begin
      case (byte_i) inside
        8'h00: begin
          partial_nxt = '0;
          res_o.valid = 1'b1;
          res_o.stop  = 1'b1;
        end
        [8'h01:8'h7F]: begin
          res_o.valid      = 1'b1;
          res_o.code_point = CodeW'(byte_i);
        end
        [8'hC0:8'hDF]: begin
          partial_nxt = PartialW'(byte_i & Lead2Mask);
          left_nxt    = LeftOne;
        end
        [8'hE0:8'hEF]: begin
          partial_nxt = PartialW'(byte_i & Lead3Mask);
          left_nxt    = LeftTwo;
        end
        [8'hF0:8'hF7]: begin
          partial_nxt = PartialW'(byte_i & Lead4Mask);
          left_nxt    = LeftThree;
        end
        default: begin
          // continuation byte or 0xf8 and above while idle
          partial_nxt = '0;
          left_nxt    = LeftIdle;
          res_o.valid = 1'b1;
          res_o.stop  = 1'b1;
        end
      endcase
    end
  end

  // sequence state moves only when a byte is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      left_r    <= LeftIdle;
    end else if (step_i) begin
      partial_r <= partial_nxt;
      left_r    <= left_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // the last continuation byte always completes a code point
  a_last_cont_emits: assert property (@(posedge clk) disable iff (!rst_n)
    step_i && (left_r == LeftOne) |-> res_o.valid && !res_o.stop)
    else $error("last continuation byte gave no code point");

  // a consumed continuation byte counts the sequence down by one
  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    step_i && (left_r != LeftIdle) |=> left_r == LeftW'($past(left_r) - LeftOne))
    else $error("continuation count did not step down");

  // a stop result carries code point zero and leaves the decoder idle
  a_stop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_o.valid && res_o.stop |-> (res_o.code_point == '0) && (left_nxt == LeftIdle))
    else $error("stop result not clean");
`endif

endmodule : ucpd_decode

`default_nettype wire

// File: src/ucpd_out_stage.sv
// ----------------------------------------------------------------------------
// ucpd_out_stage
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ucpd_out_stage (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      load_i,
  input  ucpd_pkg::ucpd_res_t            res_i,
  output logic                           space_o,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [ucpd_pkg::CodeW-1:0]     out_code_point,
  output logic                           out_stop
);
  import ucpd_pkg::*;

  logic             valid_r;
  logic             valid_nxt;
  logic [CodeW-1:0] code_r;
  logic             stop_r;

  // room for a new result when empty or being taken this cycle
  assign space_o = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load_i) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk) begin
    if (load_i) begin
      code_r <= res_i.code_point;
      stop_r <= res_i.stop;
    end
  end

  assign out_valid      = valid_r;
  assign out_code_point = code_r;
  assign out_stop       = stop_r;

endmodule : ucpd_out_stage

`default_nettype wire

// File: src/utf8_code_point_decoder_core.sv
// ----------------------------------------------------------------------------
// utf8_code_point_decoder_core
// UTF-8 byte stream to code point decoder, one byte per cycle while not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_byte_in) carries one raw byte per
//   transfer. Output channel (out_valid / out_stall / out_code_point /
//   out_stop) carries one decoded code point per transfer; lead bytes and
//   non-final continuation bytes give no output transfer.
//   A NUL byte or an invalid lead byte gives out_stop = 1 with code point 0.
//   A byte accepted into the input register is decoded combinationally from
//   that register, and its result is loaded into the result register, from
//   which it is presented on the output channel.
//   Throughput: one byte per cycle while in_stall stays low, with a single
//   decode step between the input register and the result register.
//   Reset (rst_n low, synchronous) empties both registers and returns the
//   decoder to idle with no partial value.
//   When the receiver stalls, the result register holds; the input register
//   can still take a byte that produces no result (lead or middle byte),
//   and otherwise in_stall rises until the result register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_code_point_decoder_core (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [ucpd_pkg::ByteW-1:0] in_byte_in,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [ucpd_pkg::CodeW-1:0]     out_code_point,
  output logic                           out_stop
);
  import ucpd_pkg::*;

  logic             item_valid;
  logic [ByteW-1:0] item_byte;
  logic             advance;
  logic             space;
  ucpd_res_t        res;

  // the held byte moves on when it gives no result or the result has room
  assign advance = item_valid && (!res.valid || space);

  ucpd_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_byte      (in_byte_in),
    .in_stall     (in_stall),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_byte_o  (item_byte)
  );

  ucpd_decode u_dec (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (advance),
    .byte_i (item_byte),
    .res_o  (res)
  );

  ucpd_out_stage u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .load_i         (advance && res.valid),
    .res_i          (res),
    .space_o        (space),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code_point (out_code_point),
    .out_stop       (out_stop)
  );

`ifndef NO_ASSERTIONS
  // input stall only while a byte is held and blocked by a full result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> item_valid && res.valid && out_valid && out_stall)
    else $error("input stalled without a blocked result");
`endif

endmodule : utf8_code_point_decoder_core

`default_nettype wire
